// ===== rtl/htsc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the hash-tagged slot cache: sizes, reset values, codes,
// transaction payload types and the sequencer state type. No dependencies.
package htsc_pkg;

  localparam int SLOTS  = 64;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = SLOT_W + 1;

  localparam logic [31:0] MIN_SIZE_RST = 32'd16;
  localparam logic [31:0] MAX_SIZE_RST = 32'd5242880;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_ADD    = 1'b1;

  localparam logic REG_MIN_SIZE = 1'b0;
  localparam logic REG_MAX_SIZE = 1'b1;

  typedef struct packed {
    logic        command;
    logic [31:0] content_hash;
    logic [31:0] transfer_size;
    logic        copy_ok;
  } in_t;

  typedef struct packed {
    logic              is_duplicate;
    logic              slot_valid;
    logic [SLOT_W-1:0] slot_index;
    logic [31:0]       duplicates_seen;
    logic [31:0]       copy_errors;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_ALLOC,
    ST_FINISH
  } state_t;

endpackage

// ===== rtl/hash_tagged_slot_cache_fifo.sv =====
`timescale 1ns / 1ps
// Top level of the hash-tagged slot cache: tag scan, LIFO free stack, FIFO age queue.
// Depends on htsc_pkg.
//
//   channel  direction  handshake                      payload
//   in_      input      in_valid / in_stall            in_data  (in_t)
//   out_     output     out_valid / out_stall          out_data (out_t)
//   cfg_     apb slave  psel/penable/pwrite, pready=1  paddr[2:0], pwdata/prdata 32b
//
// A transaction passes the scan, decide, alloc (when an add allocates a slot) and finish
// states: one shared 32-bit tag comparator walks the tag memory one entry a cycle, the
// compare pipe (tag read and compare-valid registers) drains, the decide state picks
// a slot and ST_ALLOC allocates it. rst_n is synchronous; no clearing pass is needed.
// The output register holds a result under out_stall while the next one is taken.
module hash_tagged_slot_cache_fifo
  import htsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  state_t state_r, state_nxt;

  logic [31:0] min_size_r, max_size_r;
  in_t         item_r;

  logic [SLOTS-1:0] tag_valid_r;
  logic [31:0]      tag_mem [SLOTS];
  logic [31:0]      tag_rd_r;

  logic [SLOT_W-1:0] fs_mem [SLOTS];
  logic [SLOTS-1:0]  fs_wr_r;
  logic [SLOT_W-1:0] fs_rd_r, fs_rd_idx_r;
  logic              fs_rd_wr_r;
  logic [CNT_W-1:0]  free_cnt_r;

  logic [SLOT_W-1:0] aq_mem [SLOTS];
  logic [SLOT_W-1:0] aq_rd_r, aq_head_r, aq_tail_r;
  logic [CNT_W-1:0]  age_cnt_r;

  logic [CNT_W-1:0]  scan_cnt_r;
  logic              cmp_vld_r;
  logic [SLOT_W-1:0] cmp_idx_r;
  logic              hit_r;
  logic [SLOT_W-1:0] hit_idx_r;
  logic              src_free_r;

  logic [31:0]       dup_total_r, err_total_r;
  logic              res_dup_r, res_sv_r;
  logic [SLOT_W-1:0] res_si_r;

  logic              out_valid_r;
  out_t              out_data_r;

  logic              cfg_wr, in_acc, scan_issue, cmp_match, add_go, in_window;
  logic              fs_pop, aq_pop, fs_push, aq_push, out_load, lookup_hit;
  logic [CNT_W-1:0]  free_cnt_dec;
  logic [SLOT_W-1:0] fs_pop_addr, slot, aq_head_inc, aq_tail_inc;

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    unique case (cfg_paddr[2])
      REG_MIN_SIZE: cfg_prdata = min_size_r;
      REG_MAX_SIZE: cfg_prdata = max_size_r;
      default:      cfg_prdata = '0;
    endcase
  end

  assign in_acc      = in_valid && !in_stall;
  assign scan_issue  = (state_r == ST_SCAN) && !scan_cnt_r[CNT_W-1];
  assign cmp_match   = cmp_vld_r && tag_valid_r[cmp_idx_r] &&
                       (tag_rd_r == item_r.content_hash);
  assign in_window   = (item_r.transfer_size >= min_size_r) &&
                       (item_r.transfer_size <= max_size_r);
  assign lookup_hit  = (item_r.command == CMD_LOOKUP) && in_window && hit_r;
  assign add_go      = (item_r.command == CMD_ADD) &&
                       (item_r.transfer_size <= max_size_r) && !hit_r;
  assign fs_pop      = (state_r == ST_DECIDE) && add_go && (free_cnt_r != '0);
  assign aq_pop      = (state_r == ST_DECIDE) && add_go && (free_cnt_r == '0) &&
                       (age_cnt_r != '0);
  assign free_cnt_dec = free_cnt_r - CNT_W'(1);
  assign fs_pop_addr  = free_cnt_dec[SLOT_W-1:0];
  assign slot         = src_free_r ? (fs_rd_wr_r ? fs_rd_r : fs_rd_idx_r) : aq_rd_r;
  assign fs_push     = (state_r == ST_ALLOC) && !item_r.copy_ok &&
                       (free_cnt_r < CNT_W'(SLOTS));
  assign aq_push     = (state_r == ST_ALLOC) && item_r.copy_ok &&
                       (age_cnt_r < CNT_W'(SLOTS));
  assign aq_head_inc = (aq_head_r == SLOT_W'(SLOTS - 1)) ? '0 : aq_head_r + 1'b1;
  assign aq_tail_inc = (aq_tail_r == SLOT_W'(SLOTS - 1)) ? '0 : aq_tail_r + 1'b1;
  assign out_load    = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_cnt_r[CNT_W-1] && !cmp_vld_r) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_nxt = (fs_pop || aq_pop) ? ST_ALLOC : ST_FINISH;
      end
      ST_ALLOC: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_size_r <= MIN_SIZE_RST;
      max_size_r <= MAX_SIZE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_MIN_SIZE: min_size_r <= cfg_pwdata;
        REG_MAX_SIZE: max_size_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) item_r <= in_data;
  end

  // tag memory: one read per scan cycle, one write on allocation with copy_ok
  always_ff @(posedge clk) begin
    if (scan_issue) tag_rd_r <= tag_mem[scan_cnt_r[SLOT_W-1:0]];
    if (aq_push) tag_mem[slot] <= item_r.content_hash;
  end

  always_ff @(posedge clk) begin
    if (fs_pop) fs_rd_r <= fs_mem[fs_pop_addr];
    if (fs_push) fs_mem[free_cnt_r[SLOT_W-1:0]] <= slot;
  end

  always_ff @(posedge clk) begin
    if (aq_pop) aq_rd_r <= aq_mem[aq_head_r];
    if (aq_push) aq_mem[aq_tail_r] <= slot;
  end

  always_ff @(posedge clk) begin
    if (fs_pop) begin
      fs_rd_idx_r <= fs_pop_addr;
      fs_rd_wr_r  <= fs_wr_r[fs_pop_addr];
    end
    if (state_r == ST_DECIDE) src_free_r <= fs_pop;
    if (scan_issue) cmp_idx_r <= scan_cnt_r[SLOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_valid_r <= '0;
      fs_wr_r     <= '0;
      free_cnt_r  <= CNT_W'(SLOTS);
      aq_head_r   <= '0;
      aq_tail_r   <= '0;
      age_cnt_r   <= '0;
      scan_cnt_r  <= '0;
      cmp_vld_r   <= 1'b0;
      hit_r       <= 1'b0;
      hit_idx_r   <= '0;
      dup_total_r <= '0;
      err_total_r <= '0;
      res_dup_r   <= 1'b0;
      res_sv_r    <= 1'b0;
      res_si_r    <= '0;
    end else begin
      cmp_vld_r <= scan_issue;
      if (in_acc) begin
        scan_cnt_r <= '0;
        hit_r      <= 1'b0;
      end
      if (scan_issue) scan_cnt_r <= scan_cnt_r + 1'b1;
      if (cmp_match && !hit_r) begin
        hit_r     <= 1'b1;
        hit_idx_r <= cmp_idx_r;
      end
      if (state_r == ST_DECIDE) begin
        res_sv_r  <= lookup_hit;
        res_si_r  <= lookup_hit ? hit_idx_r : '0;
        res_dup_r <= lookup_hit && item_r.copy_ok;
        if (lookup_hit && item_r.copy_ok) dup_total_r <= dup_total_r + 32'd1;
      end
      if (fs_pop) free_cnt_r <= free_cnt_dec;
      if (aq_pop) begin
        aq_head_r <= aq_head_inc;
        age_cnt_r <= age_cnt_r - CNT_W'(1);
      end
      if (state_r == ST_ALLOC) begin
        tag_valid_r[slot] <= item_r.copy_ok;
        if (item_r.copy_ok) begin
          res_sv_r <= 1'b1;
          res_si_r <= slot;
        end else begin
          err_total_r <= err_total_r + 32'd1;
        end
      end
      if (fs_push) begin
        fs_wr_r[free_cnt_r[SLOT_W-1:0]] <= 1'b1;
        free_cnt_r <= free_cnt_r + CNT_W'(1);
      end
      if (aq_push) begin
        aq_tail_r <= aq_tail_inc;
        age_cnt_r <= age_cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.is_duplicate    <= res_dup_r;
      out_data_r.slot_valid      <= res_sv_r;
      out_data_r.slot_index      <= res_si_r;
      out_data_r.duplicates_seen <= dup_total_r;
      out_data_r.copy_errors     <= err_total_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_slot_conserve: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (free_cnt_r + age_cnt_r == CNT_W'(SLOTS)))
    else $error("free and age counts do not cover all slots");

  a_valid_matches_age: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> ($countones(tag_valid_r) == 32'(age_cnt_r)))
    else $error("tag valid bits disagree with age queue fill");

  a_hit_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECIDE && hit_r) |-> tag_valid_r[hit_idx_r])
    else $error("hit reported on an invalid tag");

  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result presented outside finish state");
`endif

endmodule
